// File: rtl/cte_pkg.sv
package cte_pkg;

	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int SECOND_W = 6;
	localparam int SECS_W   = 39;

	localparam int DAYS_W   = 24;
	localparam int HMS_W    = 17;
	localparam int Q100_W   = 8;
	localparam int DBM_W    = 9;

	// floor(y / 100) = (y * 20972) >> 21, exact for y < 2^15
	localparam int RECIP100_W     = 15;
	localparam int RECIP100_SHIFT = 21;
	localparam logic [RECIP100_W-1:0] RECIP100 = 15'd20972;

	localparam logic [DAYS_W-1:0] EPOCH_DAYS_M1 = 24'd719529;
	localparam logic [HMS_W-1:0]  HMS_MAX       = 17'd115443;
	localparam logic [17:0]       SECS_PER_DAY  = 18'd86400;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	typedef struct packed {
		logic signed [DAYS_W-1:0] days;
		logic        [HMS_W-1:0]  hms;
	} days_t;

	function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
		logic [DBM_W-1:0] r;
		case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/cte_if.sv
interface cte_date_if;
	logic                            valid;
	logic                            ready;
	logic [cte_pkg::YEAR_W-1:0]      year;
	logic [cte_pkg::MONTH_W-1:0]     month;
	logic [cte_pkg::DAY_W-1:0]       day;
	logic [cte_pkg::HOUR_W-1:0]      hour;
	logic [cte_pkg::MINUTE_W-1:0]    minute;
	logic [cte_pkg::SECOND_W-1:0]    second;

	modport source(output valid, year, month, day, hour, minute, second, input ready);
	modport sink(input valid, year, month, day, hour, minute, second, output ready);
endinterface

interface cte_secs_if;
	logic                               valid;
	logic                               ready;
	logic signed [cte_pkg::SECS_W-1:0]  epoch_seconds;

	modport source(output valid, epoch_seconds, input ready);
	modport sink(input valid, epoch_seconds, output ready);
endinterface

// File: rtl/cte_day_count.sv
module cte_day_count (
	input  logic                clk,
	input  logic                arst_n,
	cte_date_if.sink            date_in,
	output logic                out_valid,
	input  logic                out_ready,
	output cte_pkg::days_t      out_data
);

	logic en1, en2, en3;

	// stage 1: month clamp, year / 100, time of day
	logic                              v_s1;
	logic [cte_pkg::YEAR_W-1:0]        yr_s1;
	logic [cte_pkg::MONTH_W-1:0]       mon_s1;
	logic [cte_pkg::DAY_W-1:0]         day_s1;
	logic [cte_pkg::Q100_W-1:0]        q_s1;
	logic [cte_pkg::HMS_W-1:0]         hms_s1;

	// stage 2: leap and ceiling terms
	logic                              v_s2;
	logic [22:0]                       y365_s2;
	logic [12:0]                       c4_s2;
	logic [cte_pkg::Q100_W-1:0]        q_s2;
	logic                              z100_s2;
	logic [cte_pkg::DBM_W-1:0]         dbm_s2;
	logic                              leap_add_s2;
	logic [cte_pkg::DAY_W-1:0]         day_s2;
	logic [cte_pkg::HMS_W-1:0]         hms_s2;

	// stage 3: day count relative to epoch
	logic                              v_s3;
	cte_pkg::days_t                    res_s3;

	logic [28:0]                       q_prod;
	logic [cte_pkg::MONTH_W-1:0]       mon_cl;
	logic [cte_pkg::HMS_W-1:0]         hms_c;
	logic                              z100_c;
	logic                              leap_c;
	logic [cte_pkg::DAYS_W-1:0]        c100_c;
	logic [cte_pkg::DAYS_W-1:0]        c400_c;
	logic [cte_pkg::DAYS_W-1:0]        days_c;

	assign en3 = !v_s3 || out_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign date_in.ready = en1;
	assign out_valid     = v_s3;
	assign out_data      = res_s3;

	always_comb begin
		q_prod = 29'(date_in.year) * 29'(cte_pkg::RECIP100);
		if (date_in.month < cte_pkg::MONTH_JAN) begin
			mon_cl = cte_pkg::MONTH_JAN;
		end else if (date_in.month > cte_pkg::MONTH_DEC) begin
			mon_cl = cte_pkg::MONTH_DEC;
		end else begin
			mon_cl = date_in.month;
		end
		hms_c = 17'(date_in.hour) * 17'd3600 + 17'(date_in.minute) * 17'd60
			+ 17'(date_in.second);
	end

	always_comb begin
		z100_c = (15'(yr_s1) == 15'(q_s1) * 15'd100);
		leap_c = (yr_s1[1:0] == 2'b00) && (!z100_c || (q_s1[1:0] == 2'b00));
	end

	always_comb begin
		c100_c = 24'(q_s2) + 24'(!z100_s2);
		c400_c = 24'(q_s2[cte_pkg::Q100_W-1:2]) + 24'(!(z100_s2 && (q_s2[1:0] == 2'b00)));
		days_c = 24'(y365_s2) + 24'(c4_s2) - c100_c + c400_c + 24'(dbm_s2)
			+ 24'(leap_add_s2) + 24'(day_s2) - cte_pkg::EPOCH_DAYS_M1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= date_in.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && date_in.valid) begin
			yr_s1  <= date_in.year;
			mon_s1 <= mon_cl;
			day_s1 <= date_in.day;
			q_s1   <= q_prod[cte_pkg::RECIP100_SHIFT +: cte_pkg::Q100_W];
			hms_s1 <= hms_c;
		end
		if (en2 && v_s1) begin
			y365_s2     <= 23'(yr_s1) * 23'd365;
			c4_s2       <= 13'((15'(yr_s1) + 15'd3) >> 2);
			q_s2        <= q_s1;
			z100_s2     <= z100_c;
			dbm_s2      <= cte_pkg::days_before_month(mon_s1);
			leap_add_s2 <= leap_c && (mon_s1 > cte_pkg::MONTH_FEB);
			day_s2      <= day_s1;
			hms_s2      <= hms_s1;
		end
		if (en3 && v_s2) begin
			res_s3.days <= $signed(days_c);
			res_s3.hms  <= hms_s2;
		end
	end

`ifndef NO_ASSERTIONS
	a_q100: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (15'(q_s1) * 15'd100 <= 15'(yr_s1))
			&& (15'(yr_s1) - 15'(q_s1) * 15'd100 < 15'd100))
		else $error("year / 100 quotient out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !en3 |=> v_s3 && $stable(res_s3))
		else $error("stage 3 changed while stalled");
	a_days_lo: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> res_s3.days >= -$signed(cte_pkg::EPOCH_DAYS_M1))
		else $error("day count below year zero");
`endif

endmodule

// File: rtl/cte_sec_scale.sv
module cte_sec_scale (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cte_pkg::days_t      in_data,
	cte_secs_if.source          secs_out
);

	logic en4, en5;

	logic                              v_s4;
	logic [cte_pkg::SECS_W-1:0]        prod_s4;
	logic [cte_pkg::HMS_W-1:0]         hms_s4;

	logic                              v_s5;
	logic [cte_pkg::SECS_W-1:0]        sec_s5;

	logic signed [41:0]                prod_c;

	assign en5      = !v_s5 || secs_out.ready;
	assign en4      = !v_s4 || en5;
	assign in_ready = en4;

	assign secs_out.valid         = v_s5;
	assign secs_out.epoch_seconds = $signed(sec_s5);

	always_comb begin
		prod_c = 42'(in_data.days) * $signed(42'(cte_pkg::SECS_PER_DAY));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en4) v_s4 <= in_valid;
			if (en5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && in_valid) begin
			prod_s4 <= prod_c[cte_pkg::SECS_W-1:0];
			hms_s4  <= in_data.hms;
		end
		if (en5 && v_s4) begin
			sec_s5 <= prod_s4 + 39'(hms_s4);
		end
	end

`ifndef NO_ASSERTIONS
	a_hms: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> hms_s4 <= cte_pkg::HMS_MAX)
		else $error("time of day out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !en4 |=> v_s4 && $stable(prod_s4) && $stable(hms_s4))
		else $error("stage 4 changed while stalled");
	a_sum: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && en5 |=> v_s5 && (sec_s5 == $past(prod_s4) + 39'($past(hms_s4))))
		else $error("seconds sum mismatch");
`endif

endmodule

// File: rtl/calendar_to_epoch_seconds.sv
// Gregorian date and time to signed seconds since 1970-01-01 00:00:00.
// Pipeline: 3 day-count stages, then a stage that multiplies by 86400 and
// a stage that adds the time of day; every stage is registered.
// Throughput: one beat per cycle; each stage holds under backpressure.
// Reset: arst_n clears the stage valid bits only; the datapath registers are not reset.
module calendar_to_epoch_seconds (
	input  logic        clk,
	input  logic        arst_n,
	cte_date_if.sink    date_in,
	cte_secs_if.source  secs_out
);

	logic              mid_valid;
	logic              mid_ready;
	cte_pkg::days_t    mid_data;

	cte_day_count u_day_count (
		.clk       (clk),
		.arst_n    (arst_n),
		.date_in   (date_in),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_data  (mid_data)
	);

	cte_sec_scale u_sec_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (mid_valid),
		.in_ready (mid_ready),
		.in_data  (mid_data),
		.secs_out (secs_out)
	);

endmodule
